>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk_sig, rst_n_sig, cond, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error(msg);

`endif

>>> design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, constants and tables of the seven-segment scan driver
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int unsigned SEG_W       = 8;
	localparam int unsigned SHIFT_BITS  = 8;
	localparam int unsigned BUF_DEPTH   = 4;
	localparam int unsigned DIGITS_DEF  = 4;
	localparam int unsigned IDX_W       = 2;
	localparam int unsigned ANODE_W     = 4;
	localparam int unsigned NUM_W       = 15;
	localparam int unsigned REM_W       = 14;
	localparam int unsigned BCD_W       = 8;
	// power of two, pointers wrap on their own
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [NUM_W-1:0]   NUMBER_MAX  = NUM_W'(9999);
	localparam logic [ANODE_W-1:0] ANODE_FIRST = 4'h8;
	localparam logic [ANODE_W-1:0] ANODES_OFF  = 4'hF;
	localparam logic [SEG_W-1:0]   BLANK_CODE  = 8'h00;

	// result slots of one tick
	localparam int unsigned TICK_LEN  = 2 * SHIFT_BITS + 3;
	localparam int unsigned SLOT_W    = 5;
	localparam int unsigned LATCH_ONE = SHIFT_BITS;
	localparam int unsigned SLOT_OFF  = SHIFT_BITS + 1;
	localparam int unsigned SEG_FIRST = SHIFT_BITS + 2;
	localparam int unsigned SLOT_LAST = TICK_LEN - 1;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_NUMBER = 2'd1,
		CMD_CLOCK  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// one scan tick as queued between front and back
	typedef struct packed {
		logic [SEG_W-1:0]   seg;
		logic [ANODE_W-1:0] anode_on;
	} tick_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic               serial_data;
		logic               latch_strobe;
		logic [ANODE_W-1:0] anode_lines;
		logic               last;
	} result_t;

	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] v);
		logic [SEG_W-1:0] c;
		case (v)
			4'd0:    c = 8'h3F;
			4'd1:    c = 8'h06;
			4'd2:    c = 8'h5B;
			4'd3:    c = 8'h4F;
			4'd4:    c = 8'h66;
			4'd5:    c = 8'h6D;
			4'd6:    c = 8'h7D;
			4'd7:    c = 8'h07;
			4'd8:    c = 8'h7F;
			4'd9:    c = 8'h6F;
			default: c = BLANK_CODE;
		endcase
		return c;
	endfunction

	// decimal weight of a conversion step: thousands, hundreds, tens
	function automatic logic [REM_W-1:0] step_weight(input logic [1:0] step);
		logic [REM_W-1:0] w;
		case (step)
			2'd0:    w = REM_W'(1000);
			2'd1:    w = REM_W'(100);
			default: w = REM_W'(10);
		endcase
		return w;
	endfunction

endpackage

>>> design/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// four-digit multiplexed seven-segment driver for a serial shift register
// ----------------------------------------------------------------------------
// input channel s_*: one command item per handshake, the command in s_tuser
//   scan tick: queued and played out as nineteen result items
//   show number (0..9999): converted digit by digit, tens and ones together,
//     front busy (s_tready low) until done; larger values are dropped silently
//   show clock and the unused code: no result items
// output channel m_*: one pin event per item, shift bits msb first, latch
//   pulses flagged in m_tuser, m_tlast on the closing latch of a tick
// with the back end idle, a taken tick passes the tick queue and the output
//   register before its first result is valid; a tick then yields one result
//   per cycle while m_tready is high
// the back end's slot counter plays out one tick at a time; a two-entry tick
//   queue lets the front keep taking commands meanwhile
// a stalled receiver holds the output register; the back end freezes and the
//   queue fills, after which s_tready drops
// reset: segments blank, scan at the leftmost digit, all anodes off
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
	parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // number[14:0], hours_bcd[22:15], minutes_bcd[30:23]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // serial_data[0], anode_lines[4:1]
	output logic [0:0]  m_tuser,  // latch_strobe[0]
	output logic        m_tlast   // last
);

	// front to queue
	logic                  push;
	ssd_pkg::tick_t        push_tick;
	// queue to back
	ssd_pkg::tick_t        head;
	ssd_pkg::q_status_t    q_status;
	logic                  pop;
	ssd_pkg::result_t      res;

	ssd_front #(
		.DIGITS(DIGITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.cmd         (s_tuser),
		.number      (s_tdata[14:0]),
		.hours_bcd   (s_tdata[22:15]),
		.minutes_bcd (s_tdata[30:23]),
		.q_status    (q_status),
		.push        (push),
		.push_tick   (push_tick)
	);

	ssd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_tick (push_tick),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// pack the result; the top tdata bits are padding
	assign m_tdata = {3'b000, res.anode_lines, res.serial_data};
	assign m_tuser = res.latch_strobe;
	assign m_tlast = res.last;

endmodule

>>> design/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// accepts commands, keeps the segment buffer and scan position, queues ticks
// ----------------------------------------------------------------------------
module ssd_front #(
	parameter int unsigned DIGITS = ssd_pkg::DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   cmd,
	input  logic [ssd_pkg::NUM_W-1:0]    number,
	input  logic [ssd_pkg::BCD_W-1:0]    hours_bcd,
	input  logic [ssd_pkg::BCD_W-1:0]    minutes_bcd,
	input  ssd_pkg::q_status_t           q_status,
	output logic                         push,
	output ssd_pkg::tick_t               push_tick
);

	typedef enum logic {ST_IDLE, ST_CONV} state_t;

	state_t                           state_q;
	logic [ssd_pkg::SEG_W-1:0]        buf_q [ssd_pkg::BUF_DEPTH];
	logic [ssd_pkg::IDX_W-1:0]        idx_q;
	logic [ssd_pkg::ANODE_W-1:0]      sel_q;
	logic [ssd_pkg::REM_W-1:0]        rem_q;
	logic [1:0]                       step_q;

	logic                             accept;
	ssd_pkg::cmd_t                    cmd_c;
	logic [ssd_pkg::IDX_W:0]          idx_inc;
	logic                             wrap;
	logic [ssd_pkg::REM_W-1:0]        weight;
	logic [3:0]                       dig;
	logic [ssd_pkg::REM_W-1:0]        rem_next;

	assign in_ready = (state_q == ST_IDLE) && !q_status.full;
	assign accept   = in_valid && in_ready;
	assign cmd_c    = ssd_pkg::cmd_t'(cmd);
	assign push     = accept && (cmd_c == ssd_pkg::CMD_TICK);
	assign push_tick.seg      = buf_q[idx_q];
	assign push_tick.anode_on = ~sel_q;

	assign idx_inc = {1'b0, idx_q} + (ssd_pkg::IDX_W+1)'(1);
	assign wrap    = (idx_inc >= (ssd_pkg::IDX_W+1)'(DIGITS));

	// one decimal digit per cycle by parallel compares against k * weight
	always_comb begin
		weight = ssd_pkg::step_weight(step_q);
		dig    = '0;
		for (int k = 1; k <= 9; k++) begin
			if (rem_q >= ssd_pkg::REM_W'(k) * weight) begin
				dig = 4'(k);
			end
		end
		rem_next = rem_q - ssd_pkg::REM_W'(dig) * weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			sel_q   <= ssd_pkg::ANODE_FIRST;
			step_q  <= '0;
			for (int i = 0; i < ssd_pkg::BUF_DEPTH; i++) begin
				buf_q[i] <= ssd_pkg::BLANK_CODE;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_c)
							ssd_pkg::CMD_TICK: begin
								if (wrap) begin
									idx_q <= '0;
									sel_q <= ssd_pkg::ANODE_FIRST;
								end else begin
									idx_q <= idx_inc[ssd_pkg::IDX_W-1:0];
									sel_q <= sel_q >> 1;
								end
							end
							ssd_pkg::CMD_NUMBER: begin
								if (number <= ssd_pkg::NUMBER_MAX) begin
									state_q <= ST_CONV;
									step_q  <= '0;
								end
							end
							ssd_pkg::CMD_CLOCK: begin
								buf_q[0] <= ssd_pkg::seg_code(minutes_bcd[3:0]);
								buf_q[1] <= ssd_pkg::seg_code(minutes_bcd[7:4]);
								buf_q[2] <= ssd_pkg::seg_code(hours_bcd[3:0]);
								buf_q[3] <= ssd_pkg::seg_code(hours_bcd[7:4]);
							end
							default: begin
							end
						endcase
					end
				end
				ST_CONV: begin
					buf_q[2'(3 - int'(step_q))] <= ssd_pkg::seg_code(dig);
					step_q <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						buf_q[0] <= ssd_pkg::seg_code(rem_next[3:0]);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// conversion remainder, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			rem_q <= number[ssd_pkg::REM_W-1:0];
		end else begin
			rem_q <= rem_next;
		end
	end

endmodule

>>> design/ssd_queue.sv
// ----------------------------------------------------------------------------
// ssd_queue
// short tick queue between front and back
// ----------------------------------------------------------------------------
module ssd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ssd_pkg::tick_t     push_tick,
	input  logic               pop,
	output ssd_pkg::tick_t     head,
	output ssd_pkg::q_status_t status
);

	localparam int unsigned PTR_W = $clog2(ssd_pkg::QUEUE_DEPTH);

	ssd_pkg::tick_t     mem_q [ssd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == (PTR_W+1)'(ssd_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tick;
		end
	end

endmodule

>>> design/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// plays one queued tick out as nineteen pin events into an output register
// ----------------------------------------------------------------------------
module ssd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ssd_pkg::tick_t     head,
	input  ssd_pkg::q_status_t q_status,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output ssd_pkg::result_t   out_res
);

	logic                              busy_q;
	logic [ssd_pkg::SLOT_W-1:0]        slot_q;
	logic [ssd_pkg::SEG_W-1:0]         seg_q;
	logic [ssd_pkg::ANODE_W-1:0]       anode_on_q;
	logic [ssd_pkg::ANODE_W-1:0]       drive_q;
	logic                              valid_q;
	ssd_pkg::result_t                  res_q;

	logic                              step;
	logic [ssd_pkg::SLOT_W-1:0]        slot;
	logic [2:0]                        bit_sel;
	ssd_pkg::result_t                  res;

	assign step = (!valid_q || out_ready) && (busy_q || !q_status.empty);
	assign pop  = step && !busy_q;
	assign slot = busy_q ? slot_q : '0;
	assign bit_sel = 3'(ssd_pkg::SLOT_W'(ssd_pkg::SLOT_LAST - 1) - slot);

	always_comb begin
		res.serial_data  = 1'b0;
		res.latch_strobe = (slot == ssd_pkg::SLOT_W'(ssd_pkg::LATCH_ONE))
			|| (slot == ssd_pkg::SLOT_W'(ssd_pkg::SLOT_LAST));
		res.last         = (slot == ssd_pkg::SLOT_W'(ssd_pkg::SLOT_LAST));
		res.anode_lines  = drive_q;
		if (slot >= ssd_pkg::SLOT_W'(ssd_pkg::SEG_FIRST)
			&& slot < ssd_pkg::SLOT_W'(ssd_pkg::SLOT_LAST)) begin
			res.serial_data = seg_q[bit_sel];
		end
		if (slot == ssd_pkg::SLOT_W'(ssd_pkg::SLOT_OFF)) begin
			res.anode_lines = ssd_pkg::ANODES_OFF;
		end else if (res.last) begin
			res.anode_lines = anode_on_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			slot_q  <= '0;
			drive_q <= ssd_pkg::ANODES_OFF;
			valid_q <= 1'b0;
		end else begin
			// a new result loads, a taken one without successor empties the register
			valid_q <= step || (valid_q && !out_ready);
			if (step) begin
				drive_q <= res.anode_lines;
				if (!busy_q) begin
					busy_q <= 1'b1;
					slot_q <= ssd_pkg::SLOT_W'(1);
				end else if (res.last) begin
					busy_q <= 1'b0;
				end else begin
					slot_q <= slot_q + ssd_pkg::SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seg_q      <= head.seg;
			anode_on_q <= head.anode_on;
		end
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

>>> design/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// port-level checks on the result channel of the scan driver
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser,
	input logic       m_tlast
);

	`ASSERT_CLK(a_hold_valid, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`ASSERT_CLK(a_last_latch, clk, arst_n, m_tvalid && m_tlast |-> m_tuser[0], "tick ends without latch")
	`ASSERT_NEVER(a_latch_data, clk, arst_n, m_tvalid && m_tuser[0] && m_tdata[0], "latch item with data set")
	`ASSERT_CLK(a_one_anode, clk, arst_n, m_tvalid |-> $countones(~m_tdata[4:1]) <= 1, "two anodes on")

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
